// ===== src/ctbrg_pkg.sv =====
// ----------------------------------------------------------------------------
// ctbrg_pkg
// Shared types, constants and codes of the clipped text blit row generator.
// ----------------------------------------------------------------------------
package ctbrg_pkg;

  // default parameter values
  localparam int MaxRowsDef  = 64;
  localparam int AddrBitsDef = 32;

  // field widths
  localparam int CoordW = 10;  // request coordinates, two's complement
  localparam int WideW  = 13;  // clip arithmetic, holds every shifted corner
  localparam int CellW  = 8;   // clipped coordinates and counts minus one
  localparam int ColW   = 9;   // column counts and word count
  localparam int OffW   = 17;  // cell offsets inside a buffer
  localparam int DataW  = 32;  // register data
  localparam int PaddrW = 5;   // six registers at byte stride four

  // register reset values
  localparam logic [DataW-1:0] ClipRst = 32'h1800_4F00;
  localparam logic [ColW-1:0]  ColsRst = 9'd80;
  localparam logic [DataW-1:0] BaseRst = 32'h0000_0000;

  // register indexes
  typedef enum logic [2:0] {
    REG_SRC_CLIP = 3'd0,
    REG_DST_CLIP = 3'd1,
    REG_SRC_COLS = 3'd2,
    REG_DST_COLS = 3'd3,
    REG_SRC_BASE = 3'd4,
    REG_DST_BASE = 3'd5
  } reg_idx_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [DataW-1:0] src_clip;
    logic [DataW-1:0] dst_clip;
    logic [ColW-1:0]  src_columns;
    logic [ColW-1:0]  dst_columns;
    logic [DataW-1:0] src_base;
    logic [DataW-1:0] dst_base;
  } cfg_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP_SRC,
    ST_CLIP_DMIN,
    ST_CLIP_DMAX,
    ST_CHECK,
    ST_MUL,
    ST_OFFS,
    ST_ADDR,
    ST_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clip_src;
    logic clip_dmin;
    logic clip_dmax;
    logic mul;
    logic offs;
    logic addr;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic last;
    logic slot_free;
  } sts_t;

endpackage

// ===== src/ctbrg_regs.sv =====
// ----------------------------------------------------------------------------
// ctbrg_regs
// APB-style register file: clip rectangles, line strides and buffer bases.
// ----------------------------------------------------------------------------
module ctbrg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ctbrg_pkg::PaddrW-1:0] paddr,
  input  logic [ctbrg_pkg::DataW-1:0]  pwdata,
  output logic [ctbrg_pkg::DataW-1:0]  prdata,
  output ctbrg_pkg::cfg_t              cfg
);
  import ctbrg_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[PaddrW-1:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_clip    <= ClipRst;
      cfg.dst_clip    <= ClipRst;
      cfg.src_columns <= ColsRst;
      cfg.dst_columns <= ColsRst;
      cfg.src_base    <= BaseRst;
      cfg.dst_base    <= BaseRst;
    end else if (wr_en) begin
      case (idx)
        REG_SRC_CLIP: cfg.src_clip    <= pwdata;
        REG_DST_CLIP: cfg.dst_clip    <= pwdata;
        REG_SRC_COLS: cfg.src_columns <= pwdata[ColW-1:0];
        REG_DST_COLS: cfg.dst_columns <= pwdata[ColW-1:0];
        REG_SRC_BASE: cfg.src_base    <= pwdata;
        REG_DST_BASE: cfg.dst_base    <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_SRC_CLIP: prdata = cfg.src_clip;
      REG_DST_CLIP: prdata = cfg.dst_clip;
      REG_SRC_COLS: prdata = DataW'(cfg.src_columns);
      REG_DST_COLS: prdata = DataW'(cfg.dst_columns);
      REG_SRC_BASE: prdata = cfg.src_base;
      REG_DST_BASE: prdata = cfg.dst_base;
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== src/ctbrg_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctbrg_ctrl
// Sequencer: clip steps, offset setup, then one row descriptor per free slot.
// ----------------------------------------------------------------------------
module ctbrg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output ctbrg_pkg::cmd_t cmd,
  input  ctbrg_pkg::sts_t sts
);
  import ctbrg_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CLIP_SRC;
        end
      end
      ST_CLIP_SRC: begin
        cmd.clip_src = 1'b1;
        state_next   = ST_CLIP_DMIN;
      end
      ST_CLIP_DMIN: begin
        cmd.clip_dmin = 1'b1;
        state_next    = ST_CLIP_DMAX;
      end
      ST_CLIP_DMAX: begin
        cmd.clip_dmax = 1'b1;
        state_next    = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = sts.empty ? ST_IDLE : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_OFFS;
      end
      ST_OFFS: begin
        cmd.offs   = 1'b1;
        state_next = ST_ADDR;
      end
      ST_ADDR: begin
        cmd.addr   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/ctbrg_dpath.sv =====
// ----------------------------------------------------------------------------
// ctbrg_dpath
// Clip arithmetic, start offsets, row address walkers and the output register.
// ----------------------------------------------------------------------------
module ctbrg_dpath #(
  parameter int MAX_ROWS  = ctbrg_pkg::MaxRowsDef,
  parameter int ADDR_BITS = ctbrg_pkg::AddrBitsDef
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ctbrg_pkg::cmd_t                     cmd,
  output ctbrg_pkg::sts_t                     sts,
  input  ctbrg_pkg::cfg_t                     cfg,
  input  logic signed [ctbrg_pkg::CoordW-1:0] dest_x,
  input  logic signed [ctbrg_pkg::CoordW-1:0] dest_y,
  input  logic signed [ctbrg_pkg::CoordW-1:0] src_x_start,
  input  logic signed [ctbrg_pkg::CoordW-1:0] src_y_start,
  input  logic signed [ctbrg_pkg::CoordW-1:0] src_x_end,
  input  logic signed [ctbrg_pkg::CoordW-1:0] src_y_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ADDR_BITS-1:0]                src_addr,
  output logic [ADDR_BITS-1:0]                dst_addr,
  output logic [ctbrg_pkg::ColW-1:0]          word_count,
  output logic                                descending,
  output logic                                last_row
);
  import ctbrg_pkg::*;

  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // working corners
  logic signed [WideW-1:0] sxs, sys, sxe, sye, dx, dy;

  // clip bounds, zero extended
  logic signed [WideW-1:0] scxmin, scxmax, scymin, scymax;
  logic signed [WideW-1:0] dcxmin, dcxmax, dcymin, dcymax;

  // clip step temporaries
  logic signed [WideW-1:0] sxs_c, sys_c, dx_m, dy_m;
  logic signed [WideW-1:0] dxe, dye, x_over, y_over;
  logic signed [WideW-1:0] diff_x, diff_y;

  // narrowed clipped values
  logic [CellW-1:0] sxs8, sys8, sxe8, sye8, dx8, dy8, xcm1, ycm1, dy_end;

  // setup registers
  logic [ColW-1:0]  word_cnt;
  logic [CellW-1:0] dx_end;
  logic [OffW-1:0]  p_ss, p_se, p_ds, p_de;
  logic [OffW-1:0]  soff, doff;
  logic [OffW-1:0]  so_start, do_start;
  logic             desc;
  logic [RowW-1:0]  rows_left;

  // row walkers
  logic [ADDR_BITS-1:0] src_ptr, dst_ptr, src_step, dst_step;

  assign scxmin = WideW'(cfg.src_clip[7:0]);
  assign scxmax = WideW'(cfg.src_clip[15:8]);
  assign scymin = WideW'(cfg.src_clip[23:16]);
  assign scymax = WideW'(cfg.src_clip[31:24]);
  assign dcxmin = WideW'(cfg.dst_clip[7:0]);
  assign dcxmax = WideW'(cfg.dst_clip[15:8]);
  assign dcymin = WideW'(cfg.dst_clip[23:16]);
  assign dcymax = WideW'(cfg.dst_clip[31:24]);

  // raise start corner to the source minimum
  assign sxs_c = (sxs > scxmin) ? sxs : scxmin;
  assign sys_c = (sys > scymin) ? sys : scymin;

  // raise destination corner to the destination minimum
  assign dx_m = (dx > dcxmin) ? dx : dcxmin;
  assign dy_m = (dy > dcymin) ? dy : dcymin;

  // destination end overhang past the destination maximum
  assign dxe    = dx + sxe - sxs;
  assign dye    = dy + sye - sys;
  assign x_over = dxe - dcxmax;
  assign y_over = dye - dcymax;

  assign diff_x = sxe - sxs;
  assign diff_y = sye - sys;

  // after a passing check every corner sits in 0..255
  assign sxs8   = sxs[CellW-1:0];
  assign sys8   = sys[CellW-1:0];
  assign sxe8   = sxe[CellW-1:0];
  assign sye8   = sye[CellW-1:0];
  assign dx8    = dx[CellW-1:0];
  assign dy8    = dy[CellW-1:0];
  assign xcm1   = diff_x[CellW-1:0];
  assign ycm1   = diff_y[CellW-1:0];
  assign dy_end = dy8 + ycm1;

  // empty request after clipping
  assign sts.empty = (sxs > scxmax) || (sxe < scxmin) ||
                     (sys > scymax) || (sye < scymin) ||
                     (dx > dcxmax)  || (dy > dcymax)  ||
                     (sxe < sxs)    || (sye < sys);

  // clip sequence on the working corners
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx  <= WideW'(dest_x);
      dy  <= WideW'(dest_y);
      sxs <= WideW'(src_x_start);
      sys <= WideW'(src_y_start);
      sxe <= WideW'(src_x_end);
      sye <= WideW'(src_y_end);
    end else if (cmd.clip_src) begin
      sxe <= (sxe < scxmax) ? sxe : scxmax;
      sye <= (sye < scymax) ? sye : scymax;
      sxs <= sxs_c;
      sys <= sys_c;
      dx  <= dx + sxs_c - sxs;
      dy  <= dy + sys_c - sys;
    end else if (cmd.clip_dmin) begin
      sxs <= sxs + dx_m - dx;
      sys <= sys + dy_m - dy;
      dx  <= dx_m;
      dy  <= dy_m;
    end else if (cmd.clip_dmax) begin
      if (x_over > 0) begin
        sxe <= sxe - x_over;
      end
      if (y_over > 0) begin
        sye <= sye - y_over;
      end
    end
  end

  // line products and counts
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      word_cnt <= ColW'(xcm1) + ColW'(1);
      dx_end   <= dx8 + xcm1;
      p_ss     <= OffW'(sys8) * OffW'(cfg.src_columns);
      p_se     <= OffW'(sye8) * OffW'(cfg.src_columns);
      p_ds     <= OffW'(dy8) * OffW'(cfg.dst_columns);
      p_de     <= OffW'(dy_end) * OffW'(cfg.dst_columns);
    end
  end

  // direction and first-row offsets
  assign soff = OffW'(sxs8) + p_ss;
  assign doff = OffW'(dx8) + p_ds;

  always_ff @(posedge clk) begin
    if (cmd.offs) begin
      desc <= doff > soff;
      if (doff > soff) begin
        so_start <= OffW'(sxe8) + p_se;
        do_start <= OffW'(dx_end) + p_de;
      end else begin
        so_start <= soff;
        do_start <= doff;
      end
    end
  end

  // row count and address walkers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      if (int'(ycm1) >= MAX_ROWS - 1) begin
        rows_left <= RowW'(MAX_ROWS - 1);
      end else begin
        rows_left <= RowW'(ycm1);
      end
    end else if (cmd.emit) begin
      rows_left <= rows_left - RowW'(1);
    end
    if (cmd.addr) begin
      src_ptr  <= ADDR_BITS'(cfg.src_base) + ADDR_BITS'({so_start, 1'b0});
      dst_ptr  <= ADDR_BITS'(cfg.dst_base) + ADDR_BITS'({do_start, 1'b0});
      src_step <= ADDR_BITS'({cfg.src_columns, 1'b0});
      dst_step <= ADDR_BITS'({cfg.dst_columns, 1'b0});
    end else if (cmd.emit) begin
      src_ptr <= desc ? (src_ptr - src_step) : (src_ptr + src_step);
      dst_ptr <= desc ? (dst_ptr - dst_step) : (dst_ptr + dst_step);
    end
  end

  assign sts.last      = (rows_left == '0);
  assign sts.slot_free = !out_valid || out_ready;

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      src_addr   <= src_ptr;
      dst_addr   <= dst_ptr;
      word_count <= word_cnt;
      descending <= desc;
      last_row   <= (rows_left == '0);
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== src/clipped_text_blit_row_generator_core.sv =====
// ----------------------------------------------------------------------------
// clipped_text_blit_row_generator_core
// Clips a text-cell rectangle copy request and emits one descriptor per row.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one copy request: destination
//   corner and inclusive source start and end cells. The request is clipped
//   against the source and then the destination clip rectangles.
//   Output channel (out_valid/out_ready) gives one row descriptor per clipped
//   row, source and destination byte addresses, cell count and direction,
//   with last_row set on the final one; at most MAX_ROWS rows per request.
//   A request that clips to nothing gives no descriptors; in_ready rises
//   again once the check step finds it empty. A nonempty request passes the
//   four clip/check steps, the offset multiply and two address setup steps,
//   then the row address walkers give one descriptor per cycle while the
//   receiver is ready. Requests are taken only between requests; in_ready
//   rises again in the same cycle that the last descriptor shows in the
//   output register. A receiver stall holds the output register and pauses
//   the row walk. Reset clears the sequencer and the output valid and loads
//   the registers with the 80x25 screen defaults. The user must write the
//   registers only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module clipped_text_blit_row_generator_core #(
  parameter int MAX_ROWS  = ctbrg_pkg::MaxRowsDef,
  parameter int ADDR_BITS = ctbrg_pkg::AddrBitsDef
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ctbrg_pkg::PaddrW-1:0]        paddr,
  input  logic [ctbrg_pkg::DataW-1:0]         pwdata,
  output logic [ctbrg_pkg::DataW-1:0]         prdata,
  output logic                                pready,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ctbrg_pkg::CoordW-1:0] dest_x,
  input  logic signed [ctbrg_pkg::CoordW-1:0] dest_y,
  input  logic signed [ctbrg_pkg::CoordW-1:0] src_x_start,
  input  logic signed [ctbrg_pkg::CoordW-1:0] src_y_start,
  input  logic signed [ctbrg_pkg::CoordW-1:0] src_x_end,
  input  logic signed [ctbrg_pkg::CoordW-1:0] src_y_end,
  // row descriptor channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ADDR_BITS-1:0]                src_addr,
  output logic [ADDR_BITS-1:0]                dst_addr,
  output logic [ctbrg_pkg::ColW-1:0]          word_count,
  output logic                                descending,
  output logic                                last_row
);
  import ctbrg_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // zero wait state port
  assign pready = 1'b1;

  // register file
  ctbrg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // sequencer
  ctbrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath
  ctbrg_dpath #(
    .MAX_ROWS  (MAX_ROWS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .dest_x      (dest_x),
    .dest_y      (dest_y),
    .src_x_start (src_x_start),
    .src_y_start (src_y_start),
    .src_x_end   (src_x_end),
    .src_y_end   (src_y_end),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .src_addr    (src_addr),
    .dst_addr    (dst_addr),
    .word_count  (word_count),
    .descending  (descending),
    .last_row    (last_row)
  );

endmodule

// ===== src/ctbrg_checker.sv =====
// ----------------------------------------------------------------------------
// ctbrg_checker
// Port-level checks of the row generator, bound to the top level.
// ----------------------------------------------------------------------------
module ctbrg_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ctbrg_pkg::ColW-1:0] word_count,
  input logic                       descending,
  input logic                       last_row
);
  import ctbrg_pkg::*;

  // reset empties the output register
  a_rst_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a request keeps the block busy in the following cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken twice in a row");

  // no new request while a request still has rows to give
  a_no_req_mid_rows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_row |-> !in_ready)
    else $error("ready while rows remain");

  // rows of one request follow back to back with one direction
  a_rows_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_row |=>
      out_valid && (descending == $past(descending)))
    else $error("row gap or direction change inside a request");

  // every descriptor copies at least one cell
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> word_count != '0)
    else $error("zero word count");

endmodule

bind clipped_text_blit_row_generator_core ctbrg_checker u_ctbrg_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .word_count (word_count),
  .descending (descending),
  .last_row   (last_row)
);
